// ----- rtl/core/ciw_pkg.sv -----
// shared types for the cbor item walker: status codes, nesting level state,
// result record and the level helper functions
// no dependencies
`timescale 1ns / 1ps

package ciw_pkg;

  typedef enum logic [2:0] {
    ST_MORE      = 3'd0,
    ST_DONE      = 3'd1,
    ST_RESERVED  = 3'd2,
    ST_BAD_MAJOR = 3'd3,
    ST_TRUNCATED = 3'd4,
    ST_TRAILING  = 3'd5,
    ST_DEPTH     = 3'd6,
    ST_NOT_MAP   = 3'd7
  } status_t;

  // state of one open array or map
  typedef struct packed {
    logic [63:0] cnt;
    logic        is_map;
    logic        want;
  } level_t;

  // one result per input byte
  typedef struct packed {
    status_t     status;
    logic        head_valid;
    logic [2:0]  major_type;
    logic [63:0] argument;
    logic [4:0]  nest_depth;
  } res_t;

  // true when one more finished item closes this level
  function automatic logic lv_closes(level_t lv);
    return (!lv.is_map || lv.want) && (lv.cnt == 64'd1);
  endfunction

  // level state after one more finished item, for a level that stays open
  function automatic level_t lv_update(level_t lv);
    level_t r;
    r = lv;
    if (lv.is_map && !lv.want) begin
      r.want = 1'b1;
    end else begin
      r.want = 1'b0;
      r.cnt  = lv.cnt - 64'd1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/cbor_item_walker_core.sv -----
// top level of the cbor item walker: head decode, nesting stack and status
// depends on ciw_pkg, ciw_ram and ciw_skid
`timescale 1ns / 1ps

// Checks that a byte stream, one byte per request with tlast on the final
// byte, forms exactly one well-formed definite-length CBOR item, and returns
// one result per byte: a status code in m_tdata and, when the byte completes
// an item head, the decoded major type, argument and nesting depth, flagged by
// m_tuser. The block takes one byte every cycle while the result buffer has
// room; each result is registered in a two-entry result buffer, which lets
// input keep flowing while a result waits to be taken. Each byte goes in one
// step through head decode, the argument shift register and the nesting
// stack: the top open level lives in registers, the levels below in a
// MAX_DEPTH-entry ram whose read port is aimed at the level that a pop would
// return to, so any number of levels can close at once. The stack needs no
// clearing after reset or between messages, since a level is always written
// before it is read back. Configuration writes (index 0 top_must_be_map,
// index 1 depth_limit) must be made while the block is idle.

module cbor_item_walker_core #(
  parameter int MAX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: [7:0] data_byte
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  // m_tdata: [2:0] status, [5:3] major_type, [69:6] argument,
  //          [74:70] nest_depth, [79:75] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,
  // m_tuser: [0] head_valid
  output logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = (DW > 5) ? DW : 5;
  localparam int LW = $bits(ciw_pkg::level_t);
  localparam int EW = DW + LW;

  localparam logic [0:0] REG_TOP_MAP     = 1'd0;
  localparam logic [0:0] REG_DEPTH_LIMIT = 1'd1;

  localparam logic [2:0] MT_BYTES = 3'd2;
  localparam logic [2:0] MT_TEXT  = 3'd3;
  localparam logic [2:0] MT_ARRAY = 3'd4;
  localparam logic [2:0] MT_MAP   = 3'd5;
  localparam logic [4:0] INFO_ARG1 = 5'd24;
  localparam logic [4:0] INFO_ARG8 = 5'd27;

  typedef enum logic [4:0] {
    PH_HEAD     = 5'b00001,
    PH_ARG      = 5'b00010,
    PH_PAYLOAD  = 5'b00100,
    PH_COMPLETE = 5'b01000,
    PH_ERROR    = 5'b10000
  } phase_t;

  // configuration
  logic       top_must_be_map;
  logic [4:0] depth_limit;

  // walker state
  phase_t            phase, phase_next;
  logic [3:0]        arg_left, arg_left_next;
  logic [63:0]       accum, accum_next;
  logic [63:0]       payload, payload_next;
  logic [2:0]        pend_major, pend_major_next;
  ciw_pkg::level_t   top_lv, top_lv_next;
  logic [DW-1:0]     chain_base, chain_base_next;
  ciw_pkg::level_t   chain_land, chain_land_next;
  logic [DW-1:0]     depth, depth_next;
  ciw_pkg::status_t  sticky, sticky_next;
  logic              pop_pending, pop_next;

  // stack ram
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;

  logic [DW-1:0]     cur_base;
  ciw_pkg::level_t   cur_land;

  logic              s_acc;
  logic              res_ready;
  ciw_pkg::res_t     res;
  ciw_pkg::res_t     m_res;

  // step temporaries
  logic [2:0]        b_major;
  logic [4:0]        b_info;
  logic [63:0]       acc_shift;
  logic [CW-1:0]     lim_c;
  logic              hd_go;
  logic [2:0]        hd_major;
  logic [63:0]       hd_arg;
  logic              fin;
  ciw_pkg::status_t  err;

  assign s_tready = res_ready;
  assign s_acc    = s_tvalid && s_tready;

  // chain fields of the top level come from the ram right after a pop
  assign cur_base  = pop_pending ? ram_rdata[EW-1 -: DW] : chain_base;
  assign cur_land  = pop_pending ? ciw_pkg::level_t'(ram_rdata[LW-1:0]) : chain_land;
  assign ram_raddr = AW'(cur_base - DW'(1));

  ciw_ram #(
    .WIDTH  (EW),
    .DEPTH  (MAX_DEPTH),
    .ADDR_W (AW)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top_must_be_map <= 1'b1;
      depth_limit     <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOP_MAP:     top_must_be_map <= cfg_data[0];
        REG_DEPTH_LIMIT: depth_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    b_major   = s_tdata[7:5];
    b_info    = s_tdata[4:0];
    acc_shift = {accum[55:0], s_tdata};
    lim_c     = (CW'(depth_limit) < CW'(MAX_DEPTH)) ? CW'(depth_limit) : CW'(MAX_DEPTH);

    phase_next      = phase;
    arg_left_next   = arg_left;
    accum_next      = accum;
    payload_next    = payload;
    pend_major_next = pend_major;
    top_lv_next     = top_lv;
    chain_base_next = cur_base;
    chain_land_next = cur_land;
    depth_next      = depth;
    sticky_next     = sticky;
    pop_next        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = AW'(depth - DW'(1));
    ram_wdata       = {cur_base, cur_land};

    hd_go    = 1'b0;
    hd_major = 3'd0;
    hd_arg   = 64'd0;
    fin      = 1'b0;
    err      = ciw_pkg::ST_MORE;

    res            = '0;
    res.status     = ciw_pkg::ST_MORE;

    if (sticky == ciw_pkg::ST_MORE) begin
      unique case (phase)
        PH_HEAD: begin
          if (b_info > INFO_ARG8) begin
            err = ciw_pkg::ST_RESERVED;
          end else if (depth == '0 && top_must_be_map && b_major != MT_MAP) begin
            err = ciw_pkg::ST_NOT_MAP;
          end else if (b_major > MT_MAP) begin
            err = ciw_pkg::ST_BAD_MAJOR;
          end else if (b_info < INFO_ARG1) begin
            hd_go    = 1'b1;
            hd_major = b_major;
            hd_arg   = 64'(b_info);
          end else begin
            arg_left_next   = 4'b0001 << b_info[1:0];
            accum_next      = 64'd0;
            pend_major_next = b_major;
            phase_next      = PH_ARG;
          end
        end
        PH_ARG: begin
          accum_next    = acc_shift;
          arg_left_next = (arg_left != 4'd0) ? arg_left - 4'd1 : 4'd0;
          if (arg_left <= 4'd1) begin
            hd_go    = 1'b1;
            hd_major = pend_major;
            hd_arg   = acc_shift;
          end
        end
        PH_PAYLOAD: begin
          payload_next = (payload != 64'd0) ? payload - 64'd1 : 64'd0;
          if (payload <= 64'd1) begin
            fin = 1'b1;
          end
        end
        PH_COMPLETE: begin
          err = ciw_pkg::ST_TRAILING;
        end
        default: ;
      endcase

      if (hd_go) begin
        res.head_valid = 1'b1;
        res.major_type = hd_major;
        res.argument   = hd_arg;
        res.nest_depth = 5'(depth);
        if ((hd_major == MT_BYTES || hd_major == MT_TEXT) && hd_arg != 64'd0) begin
          payload_next = hd_arg;
          phase_next   = PH_PAYLOAD;
        end else if ((hd_major == MT_ARRAY || hd_major == MT_MAP) && hd_arg != 64'd0) begin
          if (CW'(depth) >= lim_c) begin
            err = ciw_pkg::ST_DEPTH;
          end else begin
            // old top chain goes to the ram, new level gets its own chain
            if (depth != '0) begin
              ram_we = 1'b1;
              if (ciw_pkg::lv_closes(top_lv)) begin
                chain_base_next = cur_base;
                chain_land_next = cur_land;
              end else begin
                chain_base_next = depth;
                chain_land_next = ciw_pkg::lv_update(top_lv);
              end
            end else begin
              chain_base_next = '0;
              chain_land_next = top_lv;
            end
            top_lv_next.cnt    = hd_arg;
            top_lv_next.is_map = (hd_major == MT_MAP);
            top_lv_next.want   = 1'b0;
            depth_next         = depth + DW'(1);
            phase_next         = PH_HEAD;
          end
        end else begin
          fin = 1'b1;
        end
      end

      if (fin) begin
        if (depth == '0) begin
          phase_next = PH_COMPLETE;
        end else begin
          phase_next = PH_HEAD;
          if (ciw_pkg::lv_closes(top_lv)) begin
            // close every level that runs out in one go
            depth_next  = cur_base;
            top_lv_next = cur_land;
            if (cur_base == '0) begin
              phase_next = PH_COMPLETE;
            end else begin
              pop_next = 1'b1;
            end
          end else begin
            top_lv_next = ciw_pkg::lv_update(top_lv);
          end
        end
      end

      if (err != ciw_pkg::ST_MORE) begin
        sticky_next = err;
        phase_next  = PH_ERROR;
      end
    end

    if (sticky_next != ciw_pkg::ST_MORE) begin
      res            = '0;
      res.status     = sticky_next;
    end else if (phase_next == PH_COMPLETE) begin
      res.status = s_tlast ? ciw_pkg::ST_DONE : ciw_pkg::ST_MORE;
    end else begin
      res.status = s_tlast ? ciw_pkg::ST_TRUNCATED : ciw_pkg::ST_MORE;
    end

    if (s_tlast) begin
      phase_next    = PH_HEAD;
      arg_left_next = 4'd0;
      depth_next    = '0;
      sticky_next   = ciw_pkg::ST_MORE;
      pop_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEAD;
      arg_left    <= 4'd0;
      depth       <= '0;
      sticky      <= ciw_pkg::ST_MORE;
      pop_pending <= 1'b0;
    end else if (s_acc) begin
      phase       <= phase_next;
      arg_left    <= arg_left_next;
      depth       <= depth_next;
      sticky      <= sticky_next;
      pop_pending <= pop_next;
    end else begin
      pop_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      accum      <= accum_next;
      payload    <= payload_next;
      pend_major <= pend_major_next;
      top_lv     <= top_lv_next;
      chain_base <= chain_base_next;
      chain_land <= chain_land_next;
    end else begin
      chain_base <= cur_base;
      chain_land <= cur_land;
    end
  end

  ciw_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_acc),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_res)
  );

  assign m_tdata = {5'd0, m_res.nest_depth, m_res.argument, m_res.major_type,
                    m_res.status};
  assign m_tuser = m_res.head_valid;

`ifndef ASSERT_OFF
  a_sticky_phase: assert property (@(posedge clk) disable iff (rst)
    (sticky != ciw_pkg::ST_MORE) == (phase == PH_ERROR))
    else $error("held error and error phase disagree");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(depth) <= CW'(MAX_DEPTH))
    else $error("nesting depth beyond stack size");

  a_arg_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ARG |-> arg_left != 4'd0)
    else $error("argument phase with no bytes left");

  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload != 64'd0)
    else $error("payload phase with no bytes left");

  a_pop_depth: assert property (@(posedge clk) disable iff (rst)
    pop_pending |-> depth != '0)
    else $error("pop landed on an empty stack");
`endif

endmodule

// ----- rtl/core/ciw_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ciw_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ciw_skid.sv -----
// two-entry result buffer between the walker and the output stream
// depends on ciw_pkg for the result record
`timescale 1ns / 1ps

module ciw_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ciw_pkg::res_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ciw_pkg::res_t out_data
);

  ciw_pkg::res_t slot0;
  ciw_pkg::res_t slot1;
  logic [1:0]    cnt;
  logic          push;
  logic          pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_data  = slot0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !push) begin
      slot0 <= slot1;
    end else if (push && !pop) begin
      if (cnt == 2'd0) begin
        slot0 <= in_data;
      end else begin
        slot1 <= in_data;
      end
    end else if (push && pop) begin
      // with one held, the new request takes its place
      if (cnt == 2'd1) begin
        slot0 <= in_data;
      end else begin
        slot0 <= slot1;
        slot1 <= in_data;
      end
    end
  end

endmodule

// ----- test/ciw_tb_pkg.sv -----
// register indexes and cbor head codes shared by the walker testbench files
// no dependencies
`timescale 1ns / 1ps

package ciw_tb_pkg;

  // configuration register indexes
  localparam logic [0:0] REG_TOP_MAP     = 1'd0;
  localparam logic [0:0] REG_DEPTH_LIMIT = 1'd1;

  // cbor major types
  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NINT   = 3'd1;
  localparam logic [2:0] MT_BSTR   = 3'd2;
  localparam logic [2:0] MT_TSTR   = 3'd3;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_TAG    = 3'd6;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  // additional info codes
  localparam logic [4:0] AI_ONE_BYTE     = 5'd24;
  localparam logic [4:0] AI_EIGHT_BYTES  = 5'd27;
  localparam logic [4:0] AI_RESERVED_MIN = 5'd28;

endpackage

// ----- test/ciw_walk_checker.sv -----
// walker checker: follows config writes and byte requests, predicts one result
// per byte and compares it with the result stream; depends on ciw_pkg, ciw_tb_pkg
`timescale 1ns / 1ps

module ciw_walk_checker #(
  parameter int MAX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output int          outstanding,
  output int          fail_count
);

  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [2:0] {
    WK_HEAD,
    WK_ARG,
    WK_PAYLOAD,
    WK_COMPLETE,
    WK_ERROR
  } walk_t;

  // register copies
  logic        top_map;
  logic [4:0]  lim_reg;

  // walker copy
  walk_t       walk;
  logic [3:0]  arg_left;
  logic [63:0] accum;
  logic [63:0] payload;
  logic [2:0]  pend_major;
  logic [63:0] lv_cnt  [MAX_DEPTH];
  logic        lv_map  [MAX_DEPTH];
  logic        lv_want [MAX_DEPTH];
  logic [4:0]  depth;
  ciw_pkg::status_t held_status;

  ciw_pkg::res_t walk_results [$];
  ciw_pkg::res_t pred_res;
  ciw_pkg::res_t want_res;
  int          n_seen;

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    $display("result %0d: %s got %0h expected %0h", n_seen, field, got, want);
    fail_count++;
  endtask

  task automatic clear_walk();
    walk        = WK_HEAD;
    arg_left    = '0;
    accum       = '0;
    payload     = '0;
    pend_major  = '0;
    lv_cnt      = '{default: 64'd0};
    lv_map      = '{default: 1'b0};
    lv_want     = '{default: 1'b0};
    depth       = '0;
    held_status = ciw_pkg::ST_MORE;
  endtask

  // one item done at the current level, closing every level that runs out
  task automatic item_done();
    logic [IW-1:0] t;
    bit            settled;
    settled = 1'b0;
    while (!settled) begin
      if (depth == 5'd0) begin
        walk    = WK_COMPLETE;
        settled = 1'b1;
      end else begin
        walk = WK_HEAD;
        t    = IW'(depth - 5'd1);
        if (lv_map[t] && !lv_want[t]) begin
          lv_want[t] = 1'b1;
          settled    = 1'b1;
        end else begin
          lv_want[t] = 1'b0;
          lv_cnt[t]  = lv_cnt[t] - 64'd1;
          if (lv_cnt[t] != 64'd0) begin
            settled = 1'b1;
          end else begin
            lv_map[t] = 1'b0;
            depth     = depth - 5'd1;
          end
        end
      end
    end
  endtask

  task automatic head_done(input logic [2:0] mj, input logic [63:0] arg,
                           output ciw_pkg::status_t err);
    int lim;
    lim = (int'(lim_reg) < MAX_DEPTH) ? int'(lim_reg) : MAX_DEPTH;
    err = ciw_pkg::ST_MORE;
    if ((mj == ciw_tb_pkg::MT_BSTR || mj == ciw_tb_pkg::MT_TSTR) && arg != 64'd0) begin
      payload = arg;
      walk    = WK_PAYLOAD;
    end else if ((mj == ciw_tb_pkg::MT_ARRAY || mj == ciw_tb_pkg::MT_MAP) &&
                 arg != 64'd0) begin
      if (int'(depth) >= lim) begin
        err = ciw_pkg::ST_DEPTH;
      end else begin
        lv_cnt[IW'(depth)]  = arg;
        lv_map[IW'(depth)]  = (mj == ciw_tb_pkg::MT_MAP);
        lv_want[IW'(depth)] = 1'b0;
        depth               = depth + 5'd1;
        walk                = WK_HEAD;
      end
    end else begin
      item_done();
    end
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic last,
                           output ciw_pkg::res_t r);
    ciw_pkg::status_t err;
    logic        hv;
    logic [2:0]  hm;
    logic [63:0] ha;
    logic [4:0]  hd;
    logic [2:0]  mj;
    logic [4:0]  info;
    err  = ciw_pkg::ST_MORE;
    hv   = 1'b0;
    hm   = '0;
    ha   = '0;
    hd   = '0;
    mj   = b[7:5];
    info = b[4:0];
    if (held_status == ciw_pkg::ST_MORE) begin
      case (walk)
        WK_HEAD: begin
          if (info >= ciw_tb_pkg::AI_RESERVED_MIN) begin
            err = ciw_pkg::ST_RESERVED;
          end else if (depth == 5'd0 && top_map && mj != ciw_tb_pkg::MT_MAP) begin
            err = ciw_pkg::ST_NOT_MAP;
          end else if (mj > ciw_tb_pkg::MT_MAP) begin
            err = ciw_pkg::ST_BAD_MAJOR;
          end else if (info < ciw_tb_pkg::AI_ONE_BYTE) begin
            hv = 1'b1;
            hm = mj;
            ha = 64'(info);
            hd = depth;
            head_done(mj, 64'(info), err);
          end else begin
            arg_left   = 4'(1 << (info - ciw_tb_pkg::AI_ONE_BYTE));
            accum      = '0;
            pend_major = mj;
            walk       = WK_ARG;
          end
        end
        WK_ARG: begin
          accum = {accum[55:0], b};
          if (arg_left != 4'd0) arg_left = arg_left - 4'd1;
          if (arg_left == 4'd0) begin
            hv = 1'b1;
            hm = pend_major;
            ha = accum;
            hd = depth;
            head_done(pend_major, accum, err);
          end
        end
        WK_PAYLOAD: begin
          if (payload != 64'd0) payload = payload - 64'd1;
          if (payload == 64'd0) item_done();
        end
        default: begin
          err = ciw_pkg::ST_TRAILING;
        end
      endcase
      if (err != ciw_pkg::ST_MORE) begin
        held_status = err;
        walk        = WK_ERROR;
      end
    end

    if (held_status != ciw_pkg::ST_MORE) begin
      r.status = held_status;
      hv       = 1'b0;
    end else if (walk == WK_COMPLETE) begin
      r.status = last ? ciw_pkg::ST_DONE : ciw_pkg::ST_MORE;
    end else begin
      r.status = last ? ciw_pkg::ST_TRUNCATED : ciw_pkg::ST_MORE;
    end
    r.head_valid = hv;
    r.major_type = hv ? hm : 3'd0;
    r.argument   = hv ? ha : 64'd0;
    r.nest_depth = hv ? hd : 5'd0;

    if (last) clear_walk();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      top_map = 1'b1;
      lim_reg = 5'd16;
      clear_walk();
      walk_results.delete();
      n_seen = 0;
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ciw_tb_pkg::REG_TOP_MAP:     top_map = cfg_data[0];
          ciw_tb_pkg::REG_DEPTH_LIMIT: lim_reg = cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        if (walk_results.size() == 0) begin
          flag_mismatch("unexpected result, status", 64'(m_tdata[2:0]), 64'd0);
        end else begin
          want_res = walk_results.pop_front();
          if (m_tdata[2:0] !== want_res.status)
            flag_mismatch("status", 64'(m_tdata[2:0]), 64'(want_res.status));
          if (m_tuser[0] !== want_res.head_valid)
            flag_mismatch("head_valid", 64'(m_tuser[0]), 64'(want_res.head_valid));
          if (m_tdata[5:3] !== want_res.major_type)
            flag_mismatch("major_type", 64'(m_tdata[5:3]), 64'(want_res.major_type));
          if (m_tdata[69:6] !== want_res.argument)
            flag_mismatch("argument", m_tdata[69:6], want_res.argument);
          if (m_tdata[74:70] !== want_res.nest_depth)
            flag_mismatch("nest_depth", 64'(m_tdata[74:70]), 64'(want_res.nest_depth));
          if (m_tdata[79:75] !== 5'd0)
            flag_mismatch("pad bits", 64'(m_tdata[79:75]), 64'd0);
        end
        n_seen++;
      end

      if (s_tvalid && s_tready) begin
        walk_byte(s_tdata, s_tlast, pred_res);
        walk_results.push_back(pred_res);
      end

      outstanding <= walk_results.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
// testbench top for cbor_item_walker_core: drives byte messages, config writes
// and back-pressure; depends on ciw_pkg, ciw_tb_pkg and ciw_walk_checker
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_DEPTH    = 16;
  localparam int LIMIT_CYCLES = 300000;
  localparam int N_PHASES     = 10;
  localparam int PHASE_BYTES  = 145;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = ciw_tb_pkg::REG_TOP_MAP;
  logic [4:0]  cfg_data = 5'd0;

  int outstanding;
  int fail_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit cur_top_map = 1'b1;
  logic [7:0] msg [$];

  bit map_seq   [N_PHASES] = '{1, 0, 1, 0, 1, 0, 1, 0, 0, 1};
  int limit_seq [N_PHASES] = '{16, 16, 1, 1, 0, 5, 8, 2, 16, 3};

  cbor_item_walker_core #(.MAX_DEPTH(MAX_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ciw_walk_checker #(.MAX_DEPTH(MAX_DEPTH)) u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic set_idle(input int mode);
    send_idle_pct  = (mode == 1) ? 76 : (mode == 3) ? 29 : 0;
    recv_stall_pct = (mode == 2) ? 76 : (mode == 3) ? 29 : 0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_message(input bit hold);
    for (int i = 0; i < msg.size(); i++) begin
      if (hold && i == msg.size() / 2) wait_drained();
      send_byte(msg[i], i == msg.size() - 1);
    end
  endtask

  function automatic logic [63:0] rand_arg();
    case ($urandom_range(0, 4))
      0:       return 64'($urandom_range(0, 23));
      1:       return 64'($urandom_range(0, 255));
      2:       return 64'($urandom_range(0, 65535));
      3:       return 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // head with the shortest form mostly, a longer one now and then
  task automatic put_head(input logic [2:0] mj, input logic [63:0] arg);
    int         need;
    int         sel;
    logic [4:0] info;
    if (arg < 64'd24 && $urandom_range(0, 3) != 0) begin
      msg.push_back({mj, arg[4:0]});
    end else begin
      if (arg < 64'h100) need = 0;
      else if (arg < 64'h1_0000) need = 1;
      else if (arg < 64'h1_0000_0000) need = 2;
      else need = 3;
      sel  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(need, 3)) : need;
      info = ciw_tb_pkg::AI_ONE_BYTE + 5'(sel);
      msg.push_back({mj, info});
      for (int k = (1 << sel) - 1; k >= 0; k--) msg.push_back(arg[8*k +: 8]);
    end
  endtask

  // one well-formed item; a stack of items still owed per open level
  task automatic build_message(input bit want_map);
    int         owed [$];
    int         kind;
    int         cnt;
    int         len;
    bit         first;
    logic [2:0] mj;
    msg.delete();
    owed.push_back(1);
    first = 1'b1;
    while (owed.size() != 0) begin
      if (owed[owed.size() - 1] == 0) begin
        void'(owed.pop_back());
      end else begin
        owed[owed.size() - 1] = owed[owed.size() - 1] - 1;
        kind = $urandom_range(0, 9);
        if (first && want_map) kind = 9;
        first = 1'b0;
        if (kind >= 7 && owed.size() <= 4 && msg.size() < 40) begin
          mj  = (kind == 9) ? ciw_tb_pkg::MT_MAP : ciw_tb_pkg::MT_ARRAY;
          cnt = $urandom_range(0, 3);
          put_head(mj, 64'(cnt));
          owed.push_back((mj == ciw_tb_pkg::MT_MAP) ? 2 * cnt : cnt);
        end else begin
          case (kind % 4)
            0: put_head(ciw_tb_pkg::MT_UINT, rand_arg());
            1: put_head(ciw_tb_pkg::MT_NINT, rand_arg());
            default: begin
              mj  = (kind % 4 == 2) ? ciw_tb_pkg::MT_BSTR : ciw_tb_pkg::MT_TSTR;
              len = $urandom_range(0, 5);
              put_head(mj, 64'(len));
              repeat (len) msg.push_back(8'($urandom));
            end
          endcase
        end
      end
    end
  endtask

  // nested one-pair maps to push against the depth limit
  task automatic build_chain(input int levels);
    msg.delete();
    repeat (levels) begin
      put_head(ciw_tb_pkg::MT_MAP, 64'd1);
      put_head(ciw_tb_pkg::MT_UINT, 64'($urandom_range(0, 30)));
    end
    put_head(ciw_tb_pkg::MT_UINT, rand_arg());
  endtask

  task automatic build_random();
    int  keep;
    int  pick;
    bit  want_map;
    want_map = cur_top_map ? ($urandom_range(0, 9) != 0) : bit'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 8) build_chain($urandom_range(1, 18));
    else build_message(want_map);
    pick = $urandom_range(0, 99);
    if (pick < 66) begin
    end else if (pick < 76) begin
      if (msg.size() > 1) begin
        keep = $urandom_range(1, msg.size() - 1);
        while (msg.size() > keep) void'(msg.pop_back());
      end
    end else if (pick < 84) begin
      repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
    end else if (pick < 92) begin
      msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
    end else begin
      msg.delete();
      repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
    end
  endtask

  task automatic run_directed();
    // empty map
    msg = '{{ciw_tb_pkg::MT_MAP, 5'd0}};
    send_message(1'b0);
    // reserved info wins over the not-map check
    msg = '{{ciw_tb_pkg::MT_UINT, 5'd31}};
    send_message(1'b0);
    msg = '{{ciw_tb_pkg::MT_SIMPLE, 5'd31}};
    send_message(1'b0);
    // outermost item not a map
    msg = '{{ciw_tb_pkg::MT_UINT, 5'd0}};
    send_message(1'b0);
    // bad major inside a map, then a byte while the error is held
    msg = '{{ciw_tb_pkg::MT_MAP, 5'd1}, {ciw_tb_pkg::MT_UINT, 5'd0},
            {ciw_tb_pkg::MT_TAG, 5'd0}, {ciw_tb_pkg::MT_UINT, 5'd0}};
    send_message(1'b0);
    // trailing byte after a complete item
    msg = '{{ciw_tb_pkg::MT_MAP, 5'd0}, {ciw_tb_pkg::MT_MAP, 5'd0}};
    send_message(1'b0);
    // message ends early
    msg = '{{ciw_tb_pkg::MT_MAP, 5'd1}, {ciw_tb_pkg::MT_UINT, 5'd0}};
    send_message(1'b0);
    // empty array as a value
    msg = '{{ciw_tb_pkg::MT_MAP, 5'd1}, {ciw_tb_pkg::MT_UINT, 5'd0},
            {ciw_tb_pkg::MT_ARRAY, 5'd0}};
    send_message(1'b0);
    // eight-byte argument, all ones
    msg = '{{ciw_tb_pkg::MT_MAP, 5'd1}, {ciw_tb_pkg::MT_UINT, 5'd0},
            {ciw_tb_pkg::MT_UINT, ciw_tb_pkg::AI_EIGHT_BYTES},
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message(1'b0);
  endtask

  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < LIMIT_CYCLES; cyc++) @(posedge clk);
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int sent;
    int n;
    int hold_at;
    int msg_count;
    msg_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_reg(ciw_tb_pkg::REG_TOP_MAP, 5'd1);
    write_reg(ciw_tb_pkg::REG_DEPTH_LIMIT, 5'd16);
    cur_top_map = 1'b1;
    set_idle(0);
    run_directed();

    for (ph = 0; ph < N_PHASES; ph++) begin
      write_reg(ciw_tb_pkg::REG_TOP_MAP, 5'(map_seq[ph]));
      write_reg(ciw_tb_pkg::REG_DEPTH_LIMIT, 5'(limit_seq[ph]));
      cur_top_map = map_seq[ph];
      hold_at = $urandom_range(1, 8);
      sent = 0;
      n = 0;
      while (sent < PHASE_BYTES) begin
        set_idle((msg_count / 6) % 4);
        build_random();
        send_message(n == hold_at);
        sent += msg.size();
        n++;
        msg_count++;
      end
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
